@@ sv/lim_pkg.sv @@
// ---------------------------------------------------------------------------
// lim_pkg: shared types and constants for the line interval merger
// Entry and result layouts, config indexes, default sizing.
// ---------------------------------------------------------------------------
`default_nettype none

package lim_pkg;

    localparam int LINE_W         = 31;
    localparam int MAX_RANGES_DEF = 32;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LINES  = 1'd1;

    // one stored range, both ends already known to be positive
    typedef struct packed {
        logic [LINE_W-1:0] line_end;
        logic [LINE_W-1:0] line_start;
    } entry_t;

    typedef struct packed {
        logic              clamp_enable;
        logic [LINE_W-1:0] total_lines;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] merged_start;
        logic [LINE_W-1:0] merged_end;
        logic              last_result;
        logic              empty_set;
        logic              overflow;
    } result_t;

endpackage

`default_nettype wire

@@ sv/line_interval_merger.sv @@
// ---------------------------------------------------------------------------
// line_interval_merger: sort and merge a set of line ranges
// Collects ranges, keeps them sorted by start, merges overlapping or touching ranges.
// ---------------------------------------------------------------------------
// Each request on the s_ group is one range; the request with s_tlast closes
// the set. With clamp_enable set, starts are raised to 1 and ends cut to
// total_lines; ranges with start below 1 or end before start are dropped.
// Kept ranges are inserted into a store (MAX_RANGES deep) by a sequencer that
// walks down from the top entry with one comparator, shifting up one slot each
// stored range with a larger start (at most MAX_RANGES - 1); a dropped request
// is not stored. The closing request then walks the store once, emitting
// merged ranges through a one-deep output register; m_tready backpressure
// stalls the walk.
// s_tready is low for the whole insert and merge. An empty set gives a single
// result with empty_set and m_tlast set. Once the store is full further kept
// ranges are lost and overflow is raised on every result of that set.
// Write configuration only while the block is idle.
`default_nettype none

module line_interval_merger
    import lim_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LINE_W-1:0]    cfg_wdata,
    // range requests
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // [31:0] range_start, [63:32] range_end
    input  wire logic                 s_tlast,   // last_range
    // merged results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,   // [30:0] merged_start, [61:31] merged_end
    output logic                      m_tlast,   // last_result
    output logic [1:0]                m_tuser    // [0] empty_set, [1] overflow
);

    localparam int AW = $clog2(MAX_RANGES);

    cfg_t    cfg_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    st_wr_en, st_rd_en;
    logic [AW-1:0] st_wr_addr, st_rd_addr;
    entry_t  st_wr_data, st_rd_data;
    logic    out_free;
    logic    res_emit;
    result_t res;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLAMP_ENABLE: cfg_reg.clamp_enable <= cfg_wdata[0];
                REG_TOTAL_LINES:  cfg_reg.total_lines  <= cfg_wdata;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    lim_store #(
        .DEPTH (MAX_RANGES)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    lim_ctrl #(
        .MAX_RANGES (MAX_RANGES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_start   (s_tdata[31:0]),
        .in_end     (s_tdata[63:32]),
        .in_last    (s_tlast),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .st_rd_en   (st_rd_en),
        .st_rd_addr (st_rd_addr),
        .st_rd_data (st_rd_data),
        .out_free   (out_free),
        .res_emit   (res_emit),
        .res        (res)
    );

    // output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_emit)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.merged_end, out_reg.merged_start};
    assign m_tlast  = out_reg.last_result;
    assign m_tuser  = {out_reg.overflow, out_reg.empty_set};

    // sequencer never emits into an occupied, stalled output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_emit |-> out_free)
        else $error("result emitted while output register stalled");

    // an empty-set result is always the closing one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("empty-set result without last flag");

    // a merged range is never inverted
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (out_reg.merged_start <= out_reg.merged_end))
        else $error("merged range start above end");

    // no input taken while a set is being inserted or merged
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_wr_en || st_rd_en) |-> !s_tready)
        else $error("input ready during store access");

endmodule

`default_nettype wire

@@ sv/lim_store.sv @@
// ---------------------------------------------------------------------------
// lim_store: range store
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lim_store
    import lim_pkg::*;
#(
    parameter int DEPTH = MAX_RANGES_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/lim_ctrl.sv @@
// ---------------------------------------------------------------------------
// lim_ctrl: insert / merge sequencer
// Filters each request, walks the store top-down to insert it in start
// order, and on the closing request walks it upward to merge and emit.
// ---------------------------------------------------------------------------
`default_nettype none

module lim_ctrl
    import lim_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    localparam int AW        = $clog2(MAX_RANGES),
    localparam int CW        = $clog2(MAX_RANGES + 1)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   in_start,
    input  wire logic [31:0]   in_end,
    input  wire logic          in_last,
    output logic               st_wr_en,
    output logic [AW-1:0]      st_wr_addr,
    output entry_t             st_wr_data,
    output logic               st_rd_en,
    output logic [AW-1:0]      st_rd_addr,
    input  wire entry_t        st_rd_data,
    input  wire logic          out_free,
    output logic               res_emit,
    output result_t            res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_IRD  = 3'd1;
    localparam logic [2:0] S_ICMP = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MDAT = 3'd4;
    localparam logic [2:0] S_MFIN = 3'd5;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_RANGES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              drop_reg, drop_next;
    logic              last_reg, last_next;
    entry_t            new_reg, new_next;
    logic [LINE_W-1:0] cs_reg, cs_next;
    logic [LINE_W-1:0] ce_reg, ce_next;

    logic signed [31:0] s_raw, e_raw, s_clamp, e_clamp, tot_s;
    logic               keep;
    logic               touch;
    logic [CW-1:0]      idx_inc;

    // clamp and filter of the incoming request
    always_comb
    begin
        s_raw   = signed'(in_start);
        e_raw   = signed'(in_end);
        tot_s   = signed'({1'b0, cfg.total_lines});
        s_clamp = s_raw;
        e_clamp = e_raw;
        if (cfg.clamp_enable)
        begin
            if (s_raw < 32'sd1)
            begin
                s_clamp = 32'sd1;
            end
            if (e_raw > tot_s)
            begin
                e_clamp = tot_s;
            end
        end
        keep = (s_clamp > 32'sd0) && (e_clamp >= s_clamp);
    end

    // merge compare: next start touches or overlaps the open range
    assign touch   = {1'b0, st_rd_data.line_start} <= ({1'b0, ce_reg} + 32'd1);
    assign idx_inc = idx_reg + CNT_ONE;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        drop_next  = drop_reg;
        last_next  = last_reg;
        new_next   = new_reg;
        cs_next    = cs_reg;
        ce_next    = ce_reg;
        st_wr_en   = 1'b0;
        st_wr_addr = idx_reg[AW-1:0];
        st_wr_data = new_reg;
        st_rd_en   = 1'b0;
        st_rd_addr = idx_reg[AW-1:0];
        res_emit   = 1'b0;
        res        = '{merged_start: cs_reg, merged_end: ce_reg, last_result: 1'b0,
                       empty_set: 1'b0, overflow: drop_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_last;
                    new_next  = '{line_end: e_clamp[LINE_W-1:0],
                                  line_start: s_clamp[LINE_W-1:0]};
                    if (keep && (cnt_reg != CNT_MAX))
                    begin
                        idx_next   = cnt_reg;
                        state_next = S_IRD;
                    end
                    else
                    begin
                        if (keep)
                        begin
                            drop_next = 1'b1;
                        end
                        if (in_last)
                        begin
                            idx_next   = '0;
                            state_next = (cnt_reg == '0) ? S_MFIN : S_MRD;
                        end
                    end
                end
            end

            S_IRD:
            begin
                if (idx_reg == '0)
                begin
                    st_wr_en   = 1'b1;
                    cnt_next   = cnt_reg + CNT_ONE;
                    state_next = last_reg ? S_MRD : S_IDLE;
                end
                else
                begin
                    st_rd_en   = 1'b1;
                    st_rd_addr = AW'(idx_reg - CNT_ONE);
                    state_next = S_ICMP;
                end
            end

            S_ICMP:
            begin
                st_wr_en = 1'b1;
                if (st_rd_data.line_start > new_reg.line_start)
                begin
                    // shift the larger entry up one slot
                    st_wr_data = st_rd_data;
                    idx_next   = idx_reg - CNT_ONE;
                    state_next = S_IRD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_ONE;
                    idx_next   = '0;
                    state_next = last_reg ? S_MRD : S_IDLE;
                end
            end

            S_MRD:
            begin
                st_rd_en   = 1'b1;
                state_next = S_MDAT;
            end

            S_MDAT:
            begin
                if ((idx_reg == '0) || touch || out_free)
                begin
                    if (idx_reg == '0)
                    begin
                        cs_next = st_rd_data.line_start;
                        ce_next = st_rd_data.line_end;
                    end
                    else if (touch)
                    begin
                        if (st_rd_data.line_end > ce_reg)
                        begin
                            ce_next = st_rd_data.line_end;
                        end
                    end
                    else
                    begin
                        res_emit = 1'b1;
                        cs_next  = st_rd_data.line_start;
                        ce_next  = st_rd_data.line_end;
                    end
                    idx_next   = idx_inc;
                    state_next = (idx_inc == cnt_reg) ? S_MFIN : S_MRD;
                end
            end

            S_MFIN:
            begin
                res.last_result = 1'b1;
                if (cnt_reg == '0)
                begin
                    res.empty_set    = 1'b1;
                    res.merged_start = '0;
                    res.merged_end   = '0;
                end
                if (out_free)
                begin
                    res_emit   = 1'b1;
                    cnt_next   = '0;
                    drop_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            drop_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        cs_reg  <= cs_next;
        ce_reg  <= ce_next;
    end

endmodule

`default_nettype wire

@@ tb/sv/line_interval_merger_tb.sv @@
// ---------------------------------------------------------------------------
// line_interval_merger_tb: self-checking bench for the line interval merger
// Streams sets of line ranges in and checks every merged range that comes
// out against a behavioral predictor kept inside the bench. A short table of
// hand-picked requests comes first, then random sets under varying idling.
// ---------------------------------------------------------------------------
module line_interval_merger_tb;
    import lim_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 5;
    localparam int RAND_ITEMS  = 130;
    // longest walk of the store, with some slack
    localparam int LAT_CYCLES  = 2 * MAX_RANGES_DEF + 8;
    localparam int HOLD_CYCLES = 300;

    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;

    // kinds of random sets
    typedef enum int {
        SET_MIXED,
        SET_DISJOINT,
        SET_OVERFLOW
    } set_kind_t;

    // one row of the directed table: either a register write or a range request
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [LINE_W-1:0]    reg_val;
        logic signed [31:0]   rs;
        logic signed [31:0]   re;
        bit                   close;
        bit                   fixed;   // result typed in below, not predicted
        result_t              want;
    } stim_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LINE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // [31:0] range_start, [63:32] range_end
    logic                 s_tlast   = 1'b0; // last_range
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // [30:0] merged_start, [61:31] merged_end
    logic                 m_tlast;          // last_result
    logic [1:0]           m_tuser;          // [0] empty_set, [1] overflow

    line_interval_merger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // -----------------------------------------------------------------------
    // Predictor state: its own copy of the registers and the sorted store
    // -----------------------------------------------------------------------
    bit                clamp_on;
    logic [LINE_W-1:0] doc_lines;
    entry_t            sorted_ranges [MAX_RANGES_DEF];
    int unsigned       held_count;
    bit                ranges_dropped;

    result_t           expected_ranges [$];   // merged ranges still to come out
    int                mismatches;
    int                rand_items;

    // idling knobs, read by the sender task and the receiver process
    int                sender_idle_pct;
    int                rcv_stall_pct;
    int                holds_asked;

    function automatic void push_merged(logic [LINE_W-1:0] ms, logic [LINE_W-1:0] me,
                                        bit last, bit empty);
        result_t r;
        r.merged_start = ms;
        r.merged_end   = me;
        r.last_result  = last;
        r.empty_set    = empty;
        r.overflow     = ranges_dropped;
        expected_ranges = {expected_ranges, r};
    endfunction

    // Filter and insert one range; on the closing request merge the store and
    // queue up the merged ranges.
    function automatic void predict_range(logic signed [31:0] rs, logic signed [31:0] re,
                                          bit close);
        logic signed [31:0] s;
        logic signed [31:0] e;
        int unsigned        pos;
        int                 i;
        entry_t             cur;
        s    = rs;
        e    = re;
        if (clamp_on) begin
            if (s < 32'sd1)
                s = 32'sd1;
            if (e > $signed({1'b0, doc_lines}))
                e = $signed({1'b0, doc_lines});
        end
        if (s > 32'sd0 && e >= s) begin
            if (held_count >= MAX_RANGES_DEF) begin
                ranges_dropped = 1'b1;
            end else begin
                // equal starts go after the ones already held
                pos = 0;
                while (pos < held_count && sorted_ranges[pos].line_start <= s[LINE_W-1:0])
                    pos++;
                for (i = held_count; i > pos; i--)
                    sorted_ranges[i] = sorted_ranges[i-1];
                sorted_ranges[pos].line_start = s[LINE_W-1:0];
                sorted_ranges[pos].line_end   = e[LINE_W-1:0];
                held_count++;
            end
        end
        if (!close)
            return;
        if (held_count == 0) begin
            push_merged('0, '0, 1'b1, 1'b1);
        end else begin
            cur = sorted_ranges[0];
            for (i = 1; i < held_count; i++) begin
                // overlapping or touching: extend the range being built
                if (sorted_ranges[i].line_start - 1 <= cur.line_end) begin
                    if (sorted_ranges[i].line_end > cur.line_end)
                        cur.line_end = sorted_ranges[i].line_end;
                end else begin
                    push_merged(cur.line_start, cur.line_end, 1'b0, 1'b0);
                    cur = sorted_ranges[i];
                end
            end
            push_merged(cur.line_start, cur.line_end, 1'b1, 1'b0);
        end
        held_count     = 0;
        ranges_dropped = 1'b0;
    endfunction

    // -----------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // -----------------------------------------------------------------------
    function automatic void flag_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: want s=%0d e=%0d last=%0b empty=%0b ovf=%0b,",
                     $realtime, what, want.merged_start, want.merged_end,
                     want.last_result, want.empty_set, want.overflow,
                     " got s=%0d e=%0d last=%0b empty=%0b ovf=%0b",
                     got.merged_start, got.merged_end, got.last_result,
                     got.empty_set, got.overflow);
    endfunction

    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.merged_start = m_tdata[30:0];
            got.merged_end   = m_tdata[61:31];
            got.last_result  = m_tlast;
            got.empty_set    = m_tuser[0];
            got.overflow     = m_tuser[1];
            if (expected_ranges.size() == 0) begin
                want = '0;
                flag_mismatch("result with nothing pending", want, got);
            end else begin
                want = expected_ranges.pop_front();
                if (got.merged_start !== want.merged_start ||
                    got.merged_end   !== want.merged_end   ||
                    got.last_result  !== want.last_result  ||
                    got.empty_set    !== want.empty_set    ||
                    got.overflow     !== want.overflow)
                    flag_mismatch("merged range mismatch", want, got);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request from the
    // stimulus so the merge walk backs up and s_tready stays low
    // -----------------------------------------------------------------------
    int hold_left   = 0;
    int holds_taken = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready    <= 1'b0;
            hold_left   <= 0;
            holds_taken <= 0;
        end else if (holds_taken != holds_asked) begin
            holds_taken <= holds_taken + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Offer one range request and hold it until the block takes it. tvalid
    // stays high after acceptance so back-to-back requests need no reassert.
    task automatic send_range(logic signed [31:0] rs, logic signed [31:0] re, bit close);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {re, rs};
        s_tlast  <= close;
        do
            @(posedge clk);
        while (!s_tready);
        predict_range(rs, re, close);
    endtask

    // Quiet the sender and let the block drain completely.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_ranges.size() != 0)
            @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller drops cfg_we after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LINE_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_CLAMP_ENABLE)
            clamp_on = val[0];
        else
            doc_lines = val;
    endtask

    // One random set of ranges closed by a last request.
    task automatic send_set(set_kind_t kind, bit hold_at_close);
        int                 n;
        int                 k;
        int                 j;
        int                 pick;
        int                 tmp;
        int                 order [MAX_RANGES_DEF];
        logic signed [31:0] rs;
        logic signed [31:0] re;
        case (kind)
            SET_DISJOINT: n = MAX_RANGES_DEF;
            SET_OVERFLOW: n = MAX_RANGES_DEF + $urandom_range(2, 5);
            default:      n = $urandom_range(1, 8);
        endcase
        // shuffled slots so the insert walk sees every depth
        for (k = 0; k < MAX_RANGES_DEF; k++)
            order[k] = k;
        for (k = MAX_RANGES_DEF - 1; k > 0; k--) begin
            j        = $urandom_range(k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (kind == SET_DISJOINT) begin
                // gap of two lines between neighbors: nothing merges
                rs = 32'(order[k] * 4 + 1);
                re = rs + 1;
            end else if (kind == SET_OVERFLOW) begin
                rs = $urandom_range(1, 200);
                re = rs + $urandom_range(0, 5);
            end else if (pick < 8) begin
                rs = $urandom;
                re = $urandom;
            end else if (pick < 16) begin
                rs = 32'sd0 - $urandom_range(0, 5);
                re = $urandom_range(0, 40);
            end else if (pick < 22) begin
                rs = $urandom_range(2, 60);
                re = rs - $urandom_range(1, 3);
            end else if (pick < 32) begin
                // long range, mostly cut by the clamp when it is on
                rs = $urandom_range(1, 60);
                re = rs + $urandom_range(0, 400);
            end else begin
                rs = $urandom_range(1, 60);
                re = rs + $urandom_range(0, 12);
            end
            if (hold_at_close && k == n - 1)
                holds_asked++;
            send_range(rs, re, k == n - 1);
            rand_items++;
        end
    endtask

    function automatic stim_row_t range_row(logic signed [31:0] rs, logic signed [31:0] re,
                                            bit close);
        stim_row_t r;
        r        = '{default: '0};
        r.rs     = rs;
        r.re     = re;
        r.close  = close;
        return r;
    endfunction

    // closing request with its single result known up front
    function automatic stim_row_t fixed_row(logic signed [31:0] rs, logic signed [31:0] re,
                                            logic [LINE_W-1:0] ms, logic [LINE_W-1:0] me,
                                            bit empty);
        stim_row_t r;
        r                   = range_row(rs, re, 1'b1);
        r.fixed             = 1'b1;
        r.want.merged_start = ms;
        r.want.merged_end   = me;
        r.want.last_result  = 1'b1;
        r.want.empty_set    = empty;
        r.want.overflow     = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [LINE_W-1:0] val);
        stim_row_t r;
        r         = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        stim_row_t         dir_rows [$];
        stim_row_t         row;
        bit                prev_reg;
        int                set_no;
        int                phase;
        logic [LINE_W-1:0] lines;

        clamp_on        = 1'b0;
        doc_lines       = '0;
        held_count      = 0;
        ranges_dropped  = 1'b0;
        mismatches      = 0;
        rand_items      = 0;
        sender_idle_pct = 0;
        rcv_stall_pct   = 0;
        holds_asked     = 0;

        // clamp off after reset
        dir_rows = {dir_rows, fixed_row(32'sd0, 32'sd5, '0, '0, 1'b1)};     // start zero dropped
        dir_rows = {dir_rows, fixed_row(MIN32, MAX32, '0, '0, 1'b1)};       // negative start
        dir_rows = {dir_rows, fixed_row(MAX32, MAX32, '1, '1, 1'b0)};       // top line only
        dir_rows = {dir_rows, fixed_row(32'sd5, 32'sd4, '0, '0, 1'b1)};     // end before start
        // touching, equal starts, a dropped range mid-set
        dir_rows = {dir_rows, range_row(32'sd10, 32'sd20, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd1, 32'sd3, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd4, 32'sd6, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd10, 32'sd15, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd30, -32'sd1, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd25, 32'sd28, 1'b1)};
        // nested ranges, set closed by a dropped range
        dir_rows = {dir_rows, range_row(32'sd2, 32'sd50, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd5, 32'sd6, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd51, 32'sd51, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd3, 32'sd9, 1'b0)};
        dir_rows = {dir_rows, range_row(32'sd40, -32'sd5, 1'b1)};
        // clamp on; upper bits of the enable write must be ignored
        dir_rows = {dir_rows, reg_row(REG_CLAMP_ENABLE, 31'h7FFF_FFFF)};
        dir_rows = {dir_rows, reg_row(REG_TOTAL_LINES, 31'd100)};
        dir_rows = {dir_rows, fixed_row(-32'sd50, 32'sd300, 31'd1, 31'd100, 1'b0)};
        dir_rows = {dir_rows, fixed_row(32'sd0, 32'sd0, '0, '0, 1'b1)};     // raised start > end
        dir_rows = {dir_rows, fixed_row(32'sd150, 32'sd200, '0, '0, 1'b1)}; // past the document
        dir_rows = {dir_rows, reg_row(REG_TOTAL_LINES, '0)};
        dir_rows = {dir_rows, fixed_row(32'sd1, 32'sd5, '0, '0, 1'b1)};     // empty document
        dir_rows = {dir_rows, reg_row(REG_TOTAL_LINES, '1)};
        dir_rows = {dir_rows, fixed_row(MIN32, MAX32, 31'd1, '1, 1'b0)};    // full span
        dir_rows = {dir_rows, reg_row(REG_CLAMP_ENABLE, 31'h7FFF_FFFE)};    // clamp off again

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_reg = 1'b0;
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_reg) begin
                if (!prev_reg)
                    settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                if (prev_reg)
                    cfg_we <= 1'b0;
                send_range(row.rs, row.re, row.close);
                if (row.fixed)
                    expected_ranges[expected_ranges.size() - 1] = row.want;
            end
            prev_reg = row.is_reg;
        end
        cfg_we <= 1'b0;

        // random sets; idling mode steps with progress through the items
        set_no = 0;
        while (rand_items < RAND_ITEMS) begin
            phase = rand_items * 4 / RAND_ITEMS;
            case (phase)
                0:       begin sender_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 62; rcv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  rcv_stall_pct = 62; end
                default: begin sender_idle_pct = 29; rcv_stall_pct = 29; end
            endcase
            if (set_no % 4 == 3) begin
                settle();
                write_reg(REG_CLAMP_ENABLE, 31'($urandom));
                case ($urandom_range(4))
                    0:       lines = '0;
                    2:       lines = '1;
                    3:       lines = 31'($urandom);
                    default: lines = 31'($urandom_range(1, 120));
                endcase
                write_reg(REG_TOTAL_LINES, lines);
                cfg_we <= 1'b0;
            end
            // sets 1 and 2 run with clamp off: all 32 slots come back as
            // results and the receiver holds off while the next set is already
            // queued; then the overflow set fills the store and loses the rest
            if (set_no == 1)
                send_set(SET_DISJOINT, 1'b1);
            else if (set_no == 2)
                send_set(SET_OVERFLOW, 1'b0);
            else
                send_set(SET_MIXED, 1'b0);
            set_no++;
        end

        sender_idle_pct = 0;
        rcv_stall_pct   = 0;
        settle();

        if (mismatches == 0 && expected_ranges.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/lim_pkg.sv
sv/lim_store.sv
sv/lim_ctrl.sv
sv/line_interval_merger.sv
tb/sv/line_interval_merger_tb.sv
